### sv/isv_pkg.sv
// Shared types, codes and reset constants of the irrigation supervisor.
`default_nettype none

package isv_pkg;

    // Default number of entries in the state-change history ring.
    localparam int unsigned HISTORY_DEPTH_DEF = 8;

    // Register reset values and the fallback hysteresis band.
    localparam logic [6:0]  LOW_THRESHOLD_DEF   = 7'd20;
    localparam logic [6:0]  HIGH_THRESHOLD_DEF  = 7'd30;
    localparam logic [6:0]  MOISTURE_MAX        = 7'd100;
    localparam logic [31:0] WARN_LIMIT_DEF      = 32'd60000;
    localparam logic [31:0] ERR_LIMIT_DEF       = 32'd300000;

    // Event codes carried by an input item.
    typedef enum logic [3:0] {
        OP_SAMPLE      = 4'd0,
        OP_TICK        = 4'd1,
        OP_FORCE       = 4'd2,
        OP_EXIT_FORCE  = 4'd3,
        OP_SET_STATE   = 4'd4,
        OP_REPORT_ERR  = 4'd5,
        OP_CLEAR_ERR   = 4'd6,
        OP_SET_ENABLE  = 4'd7,
        OP_READ_HIST   = 4'd8
    } t_opcode;

    // System states.
    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_WARNING  = 2'd1,
        ST_ERROR    = 2'd2,
        ST_CRITICAL = 2'd3
    } t_sys_state;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK             = 2'd0,
        STS_FORCE_REFUSED  = 2'd1,
        STS_ENABLE_REFUSED = 2'd2
    } t_status;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_LOW_THRESHOLD  = 3'd0,
        CFG_HIGH_THRESHOLD = 3'd1,
        CFG_WARN_LIMIT     = 3'd2,
        CFG_ERR_LIMIT      = 3'd3
    } t_cfg_index;

    // One input item as held in the input register.
    typedef struct packed {
        logic [3:0] opcode;
        logic [6:0] moisture;
        logic       level;
        logic [1:0] new_state;
        logic [7:0] error_code;
        logic [7:0] history_index;
    } t_item;

    // Configuration register set.
    typedef struct packed {
        logic [6:0]  low_threshold;
        logic [6:0]  high_threshold;
        logic [31:0] warn_limit;
        logic [31:0] err_limit;
    } t_cfg;

    // One history ring entry.
    typedef struct packed {
        logic [1:0]  from_state;
        logic [1:0]  to_state;
        logic [7:0]  code;
        logic [31:0] time_stamp;
    } t_hist_entry;

    // History write request from the state logic.
    typedef struct packed {
        logic        en;
        t_hist_entry entry;
    } t_log_wr;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic        pump_on;
        logic        pump_changed;
        logic [1:0]  system_state;
        logic        forced;
        logic        auto_enabled;
        logic [7:0]  last_error;
        logic [1:0]  entry_from;
        logic [1:0]  entry_to;
        logic [7:0]  entry_code;
        logic [31:0] entry_time;
        logic [3:0]  entry_count;
    } t_result;

endpackage

`default_nettype wire

### sv/isv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module isv_ram #(
    parameter int unsigned WIDTH = 44,
    parameter int unsigned DEPTH = 8,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/isv_core.sv
// Supervisor state registers and the single-pass event logic.
`default_nettype none

module isv_core #(
    parameter int unsigned HISTORY_DEPTH = isv_pkg::HISTORY_DEPTH_DEF,
    localparam int unsigned AW = $clog2(HISTORY_DEPTH),
    localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire isv_pkg::t_item       i_item,
    input  wire isv_pkg::t_cfg        i_cfg,
    input  wire isv_pkg::t_hist_entry i_entry,
    output isv_pkg::t_result          o_res,
    output isv_pkg::t_log_wr          o_log,
    output logic [AW-1:0]             o_log_addr,
    output logic [AW-1:0]             o_head_next
);

    // Architectural state.
    isv_pkg::t_sys_state r_state, n_state;
    logic                r_force, n_force;
    logic                r_en, n_en;
    logic                r_pump, n_pump;
    logic [7:0]          r_last, n_last;
    logic [31:0]         r_now, n_now;
    logic [31:0]         r_elapsed, n_elapsed;
    logic [AW-1:0]       r_head, n_head;
    logic [FW-1:0]       r_fill, n_fill;

    logic                blocked;
    logic                bad_band;
    logic [6:0]          lo_eff;
    logic [6:0]          hi_eff;
    logic                chg_req;
    logic                do_chg;
    isv_pkg::t_sys_state chg_tgt;
    logic [7:0]          chg_code;
    isv_pkg::t_status    status;
    isv_pkg::t_hist_entry entry;
    logic                hit;

    assign blocked = (r_state == isv_pkg::ST_ERROR) || (r_state == isv_pkg::ST_CRITICAL);

    // Hysteresis band, with fallback when the programmed pair is unusable.
    assign bad_band = (i_cfg.low_threshold >= i_cfg.high_threshold)
                   || (i_cfg.low_threshold > isv_pkg::MOISTURE_MAX)
                   || (i_cfg.high_threshold > isv_pkg::MOISTURE_MAX);
    assign lo_eff = bad_band ? isv_pkg::LOW_THRESHOLD_DEF : i_cfg.low_threshold;
    assign hi_eff = bad_band ? isv_pkg::HIGH_THRESHOLD_DEF : i_cfg.high_threshold;

    // The history read is in range only below the fill count.
    assign hit = (8'(r_fill) > i_item.history_index);

    // Event decode and state-change resolution.
    always_comb begin
        n_state   = r_state;
        n_force   = r_force;
        n_en      = r_en;
        n_pump    = r_pump;
        n_last    = r_last;
        n_now     = r_now;
        n_elapsed = r_elapsed;
        n_head    = r_head;
        n_fill    = r_fill;
        chg_req   = 1'b0;
        chg_tgt   = isv_pkg::ST_NORMAL;
        chg_code  = 8'd0;
        status    = isv_pkg::STS_OK;
        entry     = '0;

        unique case (isv_pkg::t_opcode'(i_item.opcode))
            isv_pkg::OP_SAMPLE: begin
                if (!r_force && r_en) begin
                    if (i_item.moisture < lo_eff) begin
                        n_pump = 1'b1;
                    end else if (i_item.moisture > hi_eff) begin
                        n_pump = 1'b0;
                    end
                end
            end
            isv_pkg::OP_TICK: begin
                n_now     = r_now + 32'd1;
                n_elapsed = r_elapsed + 32'd1;
                if (r_state == isv_pkg::ST_WARNING && n_elapsed > i_cfg.warn_limit) begin
                    chg_req = 1'b1;
                    chg_tgt = isv_pkg::ST_NORMAL;
                end else if (r_state == isv_pkg::ST_ERROR
                             && n_elapsed > i_cfg.err_limit) begin
                    chg_req = 1'b1;
                    chg_tgt = isv_pkg::ST_WARNING;
                end
            end
            isv_pkg::OP_FORCE: begin
                if (blocked) begin
                    status = isv_pkg::STS_FORCE_REFUSED;
                end else begin
                    n_force = 1'b1;
                    n_pump  = i_item.level;
                end
            end
            isv_pkg::OP_EXIT_FORCE: begin
                n_force = 1'b0;
            end
            isv_pkg::OP_SET_STATE: begin
                chg_req  = 1'b1;
                chg_tgt  = isv_pkg::t_sys_state'(i_item.new_state);
                chg_code = i_item.error_code;
            end
            isv_pkg::OP_REPORT_ERR: begin
                n_last   = i_item.error_code;
                chg_req  = 1'b1;
                chg_tgt  = isv_pkg::t_sys_state'(i_item.new_state);
                chg_code = i_item.error_code;
            end
            isv_pkg::OP_CLEAR_ERR: begin
                n_last  = 8'd0;
                chg_req = 1'b1;
                chg_tgt = isv_pkg::ST_NORMAL;
            end
            isv_pkg::OP_SET_ENABLE: begin
                if (i_item.level && blocked) begin
                    status = isv_pkg::STS_ENABLE_REFUSED;
                end else begin
                    n_en = i_item.level;
                    if (!i_item.level) begin
                        n_pump = 1'b0;
                    end
                end
            end
            isv_pkg::OP_READ_HIST: begin
                if (hit) begin
                    entry = i_entry;
                end
            end
            default: begin
            end
        endcase

        // A state change restarts the timeout and is logged at the head.
        do_chg = chg_req && (chg_tgt != r_state);
        if (do_chg) begin
            n_elapsed = 32'd0;
            if (chg_tgt == isv_pkg::ST_NORMAL) begin
                n_last = 8'd0;
                n_en   = 1'b1;
            end else begin
                if (chg_code != 8'd0) begin
                    n_last = chg_code;
                end
                if (chg_tgt == isv_pkg::ST_ERROR || chg_tgt == isv_pkg::ST_CRITICAL) begin
                    n_en   = 1'b0;
                    n_pump = 1'b0;
                end
                if (chg_tgt == isv_pkg::ST_CRITICAL) begin
                    n_force = 1'b0;
                end
            end
            n_state = chg_tgt;
            n_head  = (r_head == AW'(HISTORY_DEPTH - 1)) ? '0 : r_head + 1'b1;
            if (r_fill != FW'(HISTORY_DEPTH)) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    // State registers advance once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= isv_pkg::ST_NORMAL;
            r_force   <= 1'b0;
            r_en      <= 1'b1;
            r_pump    <= 1'b0;
            r_last    <= 8'd0;
            r_now     <= 32'd0;
            r_elapsed <= 32'd0;
            r_head    <= '0;
            r_fill    <= '0;
        end else if (i_adv) begin
            r_state   <= n_state;
            r_force   <= n_force;
            r_en      <= n_en;
            r_pump    <= n_pump;
            r_last    <= n_last;
            r_now     <= n_now;
            r_elapsed <= n_elapsed;
            r_head    <= n_head;
            r_fill    <= n_fill;
        end
    end

    // History write request.
    assign o_log.en                     = i_adv && do_chg;
    assign o_log.entry.from_state       = r_state;
    assign o_log.entry.to_state         = chg_tgt;
    assign o_log.entry.code             = chg_code;
    assign o_log.entry.time_stamp       = n_now;
    assign o_log_addr                   = r_head;
    assign o_head_next                  = i_adv ? n_head : r_head;

    // Result item.
    assign o_res.status       = status;
    assign o_res.pump_on      = n_pump;
    assign o_res.pump_changed = (isv_pkg::t_opcode'(i_item.opcode) == isv_pkg::OP_SAMPLE)
                                && (n_pump != r_pump);
    assign o_res.system_state = n_state;
    assign o_res.forced       = n_force;
    assign o_res.auto_enabled = n_en;
    assign o_res.last_error   = n_last;
    assign o_res.entry_from   = entry.from_state;
    assign o_res.entry_to     = entry.to_state;
    assign o_res.entry_code   = entry.code;
    assign o_res.entry_time   = entry.time_stamp;
    assign o_res.entry_count  = 4'(n_fill);

endmodule

`default_nettype wire

### sv/irrigation_supervisor_top.sv
// Irrigation supervisor: pump hysteresis control, state timeouts and change history.
//
// Usage: items enter on the input channel (i_in_valid / o_in_ready) and each item
// yields exactly one result item on the output channel (o_out_valid / i_out_ready).
// Configuration registers are written through i_cfg_we / i_cfg_addr / i_cfg_data
// while the block is idle; indexes beyond the register list are ignored.
// Flow: an accepted item is held in the input register, is processed by the event
// logic and is loaded into the output register once that register is free or being
// taken. Throughput is one item per cycle while the receiver takes each result.
// The history ring is a RAM with registered read; its read is issued as the item
// is accepted, and a write landing on the same entry at that edge is forwarded.
// Reset (synchronous, active low) returns the state to normal, enabled, pump off,
// empty history and default thresholds and timeouts; the ring contents are not
// cleared and need no clearing pass.
// When the receiver stalls, the result holds in the output register and one more
// item is taken into the input register; o_in_ready then drops until the result
// is taken.
`default_nettype none

module irrigation_supervisor_top #(
    parameter int unsigned HISTORY_DEPTH = isv_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [6:0]  i_moisture,
    input  wire logic        i_level,
    input  wire logic [1:0]  i_new_state,
    input  wire logic [7:0]  i_error_code,
    input  wire logic [7:0]  i_history_index,
    // Output channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic             o_pump_on,
    output logic             o_pump_changed,
    output logic [1:0]       o_system_state,
    output logic             o_forced,
    output logic             o_auto_enabled,
    output logic [7:0]       o_last_error,
    output logic [1:0]       o_entry_from,
    output logic [1:0]       o_entry_to,
    output logic [7:0]       o_entry_code,
    output logic [31:0]      o_entry_time,
    output logic [3:0]       o_entry_count
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned PW = AW + 1;
    localparam logic [8:0]  DEPTH_W = 9'(HISTORY_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(HISTORY_DEPTH);
    localparam logic [PW-1:0] DEPTH_M1 = PW'(HISTORY_DEPTH - 1);

    isv_pkg::t_cfg        r_cfg;
    isv_pkg::t_item       r_item;
    logic                 r_in_valid;
    isv_pkg::t_result     r_res;
    logic                 r_out_valid;
    logic                 r_byp;
    isv_pkg::t_hist_entry r_byp_data;

    logic                 adv;
    logic                 in_acc;
    isv_pkg::t_result     res;
    isv_pkg::t_log_wr     log_wr;
    logic [AW-1:0]        log_addr;
    logic [AW-1:0]        head_next;
    logic [PW-1:0]        pos_raw;
    logic [AW-1:0]        rd_addr;
    logic [$bits(isv_pkg::t_hist_entry)-1:0] ram_rdata;
    isv_pkg::t_hist_entry entry;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold  <= isv_pkg::LOW_THRESHOLD_DEF;
            r_cfg.high_threshold <= isv_pkg::HIGH_THRESHOLD_DEF;
            r_cfg.warn_limit     <= isv_pkg::WARN_LIMIT_DEF;
            r_cfg.err_limit      <= isv_pkg::ERR_LIMIT_DEF;
        end else if (i_cfg_we) begin
            unique case (isv_pkg::t_cfg_index'(i_cfg_addr))
                isv_pkg::CFG_LOW_THRESHOLD:  r_cfg.low_threshold  <= i_cfg_data[6:0];
                isv_pkg::CFG_HIGH_THRESHOLD: r_cfg.high_threshold <= i_cfg_data[6:0];
                isv_pkg::CFG_WARN_LIMIT:     r_cfg.warn_limit     <= i_cfg_data;
                isv_pkg::CFG_ERR_LIMIT:      r_cfg.err_limit      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Handshake: an item moves on when the output register is free or being taken.
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.opcode        <= i_opcode;
            r_item.moisture      <= i_moisture;
            r_item.level         <= i_level;
            r_item.new_state     <= i_new_state;
            r_item.error_code    <= i_error_code;
            r_item.history_index <= i_history_index;
        end
    end

    // History read address: newest entry sits just below the head after the
    // item now in flight has logged its change.
    assign pos_raw = PW'(head_next) + DEPTH_M1 - PW'(i_history_index);
    always_comb begin
        if ({1'b0, i_history_index} >= DEPTH_W) begin
            rd_addr = '0;
        end else if (pos_raw >= DEPTH_P) begin
            rd_addr = AW'(pos_raw - DEPTH_P);
        end else begin
            rd_addr = AW'(pos_raw);
        end
    end

    // Forward a history write that hits the entry being read at the same edge.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byp      <= log_wr.en && (log_addr == rd_addr);
            r_byp_data <= log_wr.entry;
        end
    end

    isv_ram #(
        .WIDTH ($bits(isv_pkg::t_hist_entry)),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (log_wr.en),
        .i_waddr (log_addr),
        .i_wdata (log_wr.entry),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign entry = r_byp ? r_byp_data : isv_pkg::t_hist_entry'(ram_rdata);

    isv_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_item      (r_item),
        .i_cfg       (r_cfg),
        .i_entry     (entry),
        .o_res       (res),
        .o_log       (log_wr),
        .o_log_addr  (log_addr),
        .o_head_next (head_next)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_res.status;
    assign o_pump_on      = r_res.pump_on;
    assign o_pump_changed = r_res.pump_changed;
    assign o_system_state = r_res.system_state;
    assign o_forced       = r_res.forced;
    assign o_auto_enabled = r_res.auto_enabled;
    assign o_last_error   = r_res.last_error;
    assign o_entry_from   = r_res.entry_from;
    assign o_entry_to     = r_res.entry_to;
    assign o_entry_code   = r_res.entry_code;
    assign o_entry_time   = r_res.entry_time;
    assign o_entry_count  = r_res.entry_count;

endmodule

`default_nettype wire

### sv/isv_checker.sv
// Port-level checker for the irrigation supervisor and its bind statement.
`default_nettype none

module isv_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_status,
    input wire logic        o_pump_on,
    input wire logic [1:0]  o_system_state,
    input wire logic        o_forced,
    input wire logic        o_auto_enabled,
    input wire logic [7:0]  o_last_error,
    input wire logic [31:0] o_entry_time
);

    logic blocked;
    assign blocked = (o_system_state == isv_pkg::ST_ERROR)
                  || (o_system_state == isv_pkg::ST_CRITICAL);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_system_state)
            && $stable(o_last_error) && $stable(o_entry_time))
        else $error("stalled result item changed");

    // The input side only stalls behind a full output register.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without a waiting result");

    // A refused force is only reported in error or critical.
    a_force_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == isv_pkg::STS_FORCE_REFUSED) |-> blocked)
        else $error("force refused outside error or critical");

    // Error and critical keep irrigation disabled and the pump off.
    a_blocked_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && blocked |-> !o_auto_enabled && !o_pump_on)
        else $error("pump or enable active in error or critical");

    // Critical never coexists with force mode.
    a_crit_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_system_state == isv_pkg::ST_CRITICAL) |-> !o_forced)
        else $error("force mode active in critical");

endmodule

bind irrigation_supervisor_top isv_checker u_isv_checker (.*);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench of the irrigation supervisor: random and directed events.
`default_nettype none

// Tracks the supervisor state, predicts each result item and checks the returned ones.
class supervisor_shadow;
    localparam int LOG_DEPTH = isv_pkg::HISTORY_DEPTH_DEF;

    // Register copies.
    logic [6:0]  band_lo;
    logic [6:0]  band_hi;
    logic [31:0] warn_limit;
    logic [31:0] err_limit;

    // Supervisor state copies.
    isv_pkg::t_sys_state  cur_state;
    logic                 manual;
    logic                 auto_on;
    logic                 pump;
    logic [7:0]           err_code;
    logic [31:0]          clock_ticks;
    logic [31:0]          entered_at;
    isv_pkg::t_hist_entry log_mem[LOG_DEPTH];
    int                   log_wr;
    int                   log_used;

    isv_pkg::t_result     awaited[$];
    int                   noted;
    int                   checked;
    int                   mismatches;

    function new();
        band_lo     = isv_pkg::LOW_THRESHOLD_DEF;
        band_hi     = isv_pkg::HIGH_THRESHOLD_DEF;
        warn_limit  = isv_pkg::WARN_LIMIT_DEF;
        err_limit   = isv_pkg::ERR_LIMIT_DEF;
        cur_state   = isv_pkg::ST_NORMAL;
        manual      = 1'b0;
        auto_on     = 1'b1;
        pump        = 1'b0;
        err_code    = '0;
        clock_ticks = '0;
        entered_at  = '0;
        log_wr      = 0;
        log_used    = 0;
        noted       = 0;
        checked     = 0;
        mismatches  = 0;
    endfunction

    function int waiting();
        return awaited.size();
    endfunction

    // A register write; indexes past the list are dropped.
    function void load_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            isv_pkg::CFG_LOW_THRESHOLD:  band_lo = value[6:0];
            isv_pkg::CFG_HIGH_THRESHOLD: band_hi = value[6:0];
            isv_pkg::CFG_WARN_LIMIT:     warn_limit = value;
            isv_pkg::CFG_ERR_LIMIT:      err_limit = value;
            default: ;
        endcase
    endfunction

    // State transition with its side effects and a history record.
    function void move_to(isv_pkg::t_sys_state tgt, logic [7:0] code);
        isv_pkg::t_sys_state prev;
        prev = cur_state;
        if (tgt == prev)
            return;
        entered_at = clock_ticks;
        if (tgt == isv_pkg::ST_NORMAL) begin
            err_code = '0;
            auto_on  = 1'b1;
        end else begin
            if (code != 8'd0)
                err_code = code;
            if (tgt == isv_pkg::ST_ERROR || tgt == isv_pkg::ST_CRITICAL) begin
                auto_on = 1'b0;
                pump    = 1'b0;
            end
            if (tgt == isv_pkg::ST_CRITICAL)
                manual = 1'b0;
        end
        cur_state = tgt;
        log_mem[log_wr].from_state = prev;
        log_mem[log_wr].to_state   = tgt;
        log_mem[log_wr].code       = code;
        log_mem[log_wr].time_stamp = clock_ticks;
        log_wr = (log_wr + 1) % LOG_DEPTH;
        if (log_used < LOG_DEPTH)
            log_used++;
    endfunction

    // Applies one accepted item and queues the result it must produce.
    function void note_item(isv_pkg::t_item it);
        isv_pkg::t_result     r;
        isv_pkg::t_hist_entry e;
        logic                 blocked;
        logic                 was;
        logic [6:0]           lo;
        logic [6:0]           hi;
        logic [31:0]          elapsed;
        r = '0;
        e = '0;
        blocked = (cur_state == isv_pkg::ST_ERROR || cur_state == isv_pkg::ST_CRITICAL);
        r.status = isv_pkg::STS_OK;
        case (it.opcode)
            isv_pkg::OP_SAMPLE: begin
                if (!manual && auto_on) begin
                    lo = band_lo;
                    hi = band_hi;
                    // An unusable band falls back to the default one.
                    if (lo >= hi || lo > isv_pkg::MOISTURE_MAX
                        || hi > isv_pkg::MOISTURE_MAX) begin
                        lo = isv_pkg::LOW_THRESHOLD_DEF;
                        hi = isv_pkg::HIGH_THRESHOLD_DEF;
                    end
                    was = pump;
                    if (it.moisture < lo)
                        pump = 1'b1;
                    else if (it.moisture > hi)
                        pump = 1'b0;
                    r.pump_changed = (was != pump);
                end
            end
            isv_pkg::OP_TICK: begin
                clock_ticks = clock_ticks + 32'd1;
                elapsed = clock_ticks - entered_at;
                if (cur_state == isv_pkg::ST_WARNING && elapsed > warn_limit)
                    move_to(isv_pkg::ST_NORMAL, 8'd0);
                else if (cur_state == isv_pkg::ST_ERROR && elapsed > err_limit)
                    move_to(isv_pkg::ST_WARNING, 8'd0);
            end
            isv_pkg::OP_FORCE: begin
                if (blocked) begin
                    r.status = isv_pkg::STS_FORCE_REFUSED;
                end else begin
                    manual = 1'b1;
                    pump   = it.level;
                end
            end
            isv_pkg::OP_EXIT_FORCE: manual = 1'b0;
            isv_pkg::OP_SET_STATE:
                move_to(isv_pkg::t_sys_state'(it.new_state), it.error_code);
            isv_pkg::OP_REPORT_ERR: begin
                err_code = it.error_code;
                move_to(isv_pkg::t_sys_state'(it.new_state), it.error_code);
            end
            isv_pkg::OP_CLEAR_ERR: begin
                err_code = '0;
                move_to(isv_pkg::ST_NORMAL, 8'd0);
            end
            isv_pkg::OP_SET_ENABLE: begin
                if (it.level && blocked) begin
                    r.status = isv_pkg::STS_ENABLE_REFUSED;
                end else begin
                    auto_on = it.level;
                    if (!it.level)
                        pump = 1'b0;
                end
            end
            isv_pkg::OP_READ_HIST: begin
                // Index 0 is the newest record; anything past the fill reads as zero.
                if (int'(it.history_index) < log_used)
                    e = log_mem[(log_wr + LOG_DEPTH - 1 - int'(it.history_index)) % LOG_DEPTH];
            end
            default: ;
        endcase
        r.pump_on      = pump;
        r.system_state = cur_state;
        r.forced       = manual;
        r.auto_enabled = auto_on;
        r.last_error   = err_code;
        r.entry_from   = e.from_state;
        r.entry_to     = e.to_state;
        r.entry_code   = e.code;
        r.entry_time   = e.time_stamp;
        r.entry_count  = 4'(log_used);
        awaited.push_back(r);
        noted++;
    endfunction

    function void complain(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch at result %0d, %s: expected %0h, got %0h",
                     checked, what, want, got);
    endfunction

    function void cmp_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
            complain(what, want, got);
    endfunction

    // Compares one returned result item with the oldest prediction.
    function void check_result(isv_pkg::t_result got);
        isv_pkg::t_result want;
        if (awaited.size() == 0) begin
            complain("result with no item outstanding", 32'd0, 32'(got.system_state));
            return;
        end
        want = awaited.pop_front();
        checked++;
        cmp_field("status",       32'(want.status),       32'(got.status));
        cmp_field("pump_on",      32'(want.pump_on),      32'(got.pump_on));
        cmp_field("pump_changed", 32'(want.pump_changed), 32'(got.pump_changed));
        cmp_field("system_state", 32'(want.system_state), 32'(got.system_state));
        cmp_field("forced",       32'(want.forced),       32'(got.forced));
        cmp_field("auto_enabled", 32'(want.auto_enabled), 32'(got.auto_enabled));
        cmp_field("last_error",   32'(want.last_error),   32'(got.last_error));
        cmp_field("entry_from",   32'(want.entry_from),   32'(got.entry_from));
        cmp_field("entry_to",     32'(want.entry_to),     32'(got.entry_to));
        cmp_field("entry_code",   32'(want.entry_code),   32'(got.entry_code));
        cmp_field("entry_time",   want.entry_time,        got.entry_time);
        cmp_field("entry_count",  32'(want.entry_count),  32'(got.entry_count));
    endfunction
endclass

module tb_top;

    localparam int QUIET_LIMIT = 5000;
    localparam int PHASE_ITEMS = 115;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_cfg_we = 1'b0;
    logic [2:0]     i_cfg_addr = '0;
    logic [31:0]    i_cfg_data = '0;
    logic           i_in_valid = 1'b0;
    logic           i_out_ready = 1'b0;
    isv_pkg::t_item drive_item = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic        o_pump_on;
    logic        o_pump_changed;
    logic [1:0]  o_system_state;
    logic        o_forced;
    logic        o_auto_enabled;
    logic [7:0]  o_last_error;
    logic [1:0]  o_entry_from;
    logic [1:0]  o_entry_to;
    logic [7:0]  o_entry_code;
    logic [31:0] o_entry_time;
    logic [3:0]  o_entry_count;
    isv_pkg::t_result seen;

    supervisor_shadow shadow = new();
    logic        no_idle = 1'b0;
    int          quiet_cycles = 0;
    int          settings_run = 1;

    irrigation_supervisor_top #(
        .HISTORY_DEPTH(isv_pkg::HISTORY_DEPTH_DEF)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (drive_item.opcode),
        .i_moisture     (drive_item.moisture),
        .i_level        (drive_item.level),
        .i_new_state    (drive_item.new_state),
        .i_error_code   (drive_item.error_code),
        .i_history_index(drive_item.history_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_pump_on      (o_pump_on),
        .o_pump_changed (o_pump_changed),
        .o_system_state (o_system_state),
        .o_forced       (o_forced),
        .o_auto_enabled (o_auto_enabled),
        .o_last_error   (o_last_error),
        .o_entry_from   (o_entry_from),
        .o_entry_to     (o_entry_to),
        .o_entry_code   (o_entry_code),
        .o_entry_time   (o_entry_time),
        .o_entry_count  (o_entry_count)
    );

    assign seen = {o_status, o_pump_on, o_pump_changed, o_system_state, o_forced,
                   o_auto_enabled, o_last_error, o_entry_from, o_entry_to, o_entry_code,
                   o_entry_time, o_entry_count};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The receiver stalls at random except during the steady stretch.
    always @(posedge i_clk) begin
        if (no_idle)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(99) >= 34);
    end

    // Every returned result item is checked against the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            shadow.check_result(seen);
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic isv_pkg::t_item mk(isv_pkg::t_opcode op, logic [6:0] moist,
                                          logic lvl, isv_pkg::t_sys_state ns,
                                          logic [7:0] code, logic [7:0] idx);
        isv_pkg::t_item it;
        it.opcode        = op;
        it.moisture      = moist;
        it.level         = lvl;
        it.new_state     = ns;
        it.error_code    = code;
        it.history_index = idx;
        return it;
    endfunction

    // Random event weighted toward samples, ticks and state changes.
    function automatic isv_pkg::t_item rand_event();
        isv_pkg::t_item it;
        int             pick;
        int             edge_pt;
        it.moisture      = 7'($urandom_range(127));
        it.level         = 1'($urandom_range(1));
        it.new_state     = 2'($urandom_range(3));
        it.error_code    = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
        it.history_index = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                    : 8'($urandom_range(9));
        pick = $urandom_range(99);
        if (pick < 25) begin
            it.opcode = isv_pkg::OP_SAMPLE;
            // Half of the samples land right around a threshold.
            if ($urandom_range(1)) begin
                case ($urandom_range(3))
                    0: edge_pt = int'(shadow.band_lo);
                    1: edge_pt = int'(shadow.band_hi);
                    2: edge_pt = int'(isv_pkg::LOW_THRESHOLD_DEF);
                    default: edge_pt = int'(isv_pkg::HIGH_THRESHOLD_DEF);
                endcase
                it.moisture = 7'(edge_pt + $urandom_range(4) - 2);
            end
        end else if (pick < 48)
            it.opcode = isv_pkg::OP_TICK;
        else if (pick < 56)
            it.opcode = isv_pkg::OP_FORCE;
        else if (pick < 61)
            it.opcode = isv_pkg::OP_EXIT_FORCE;
        else if (pick < 69)
            it.opcode = isv_pkg::OP_SET_STATE;
        else if (pick < 75)
            it.opcode = isv_pkg::OP_REPORT_ERR;
        else if (pick < 80)
            it.opcode = isv_pkg::OP_CLEAR_ERR;
        else if (pick < 87)
            it.opcode = isv_pkg::OP_SET_ENABLE;
        else if (pick < 96)
            it.opcode = isv_pkg::OP_READ_HIST;
        else
            it.opcode = 4'($urandom_range(15, int'(isv_pkg::OP_READ_HIST) + 1));
        return it;
    endfunction

    // Offers one item, with random idle cycles first, and waits for acceptance.
    task automatic send_item(input isv_pkg::t_item it);
        while (!no_idle && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        drive_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.note_item(it);
    endtask

    // Holds input back until every outstanding result item has returned.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (shadow.waiting() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        shadow.load_reg(idx, value);
        i_cfg_we   <= 1'b0;
    endtask

    // Threshold value with random bits above the register width.
    function automatic logic [31:0] junk7(int v);
        return {25'($urandom()), 7'(v)};
    endfunction

    // One register setting per phase, extremes first.
    task automatic apply_setting(input int ph);
        int lo;
        case (ph)
            1: begin
                set_reg(isv_pkg::CFG_LOW_THRESHOLD, junk7(0));
                set_reg(isv_pkg::CFG_HIGH_THRESHOLD, junk7(int'(isv_pkg::MOISTURE_MAX)));
                set_reg(isv_pkg::CFG_WARN_LIMIT, 32'd0);
                set_reg(isv_pkg::CFG_ERR_LIMIT, 32'd0);
            end
            2: begin
                set_reg(isv_pkg::CFG_LOW_THRESHOLD, junk7(127));
                set_reg(isv_pkg::CFG_HIGH_THRESHOLD, junk7(127));
                set_reg(isv_pkg::CFG_WARN_LIMIT, '1);
                set_reg(isv_pkg::CFG_ERR_LIMIT, '1);
            end
            3: begin
                set_reg(isv_pkg::CFG_LOW_THRESHOLD, junk7(50));
                set_reg(isv_pkg::CFG_HIGH_THRESHOLD, junk7(40));
                set_reg(isv_pkg::CFG_WARN_LIMIT, 32'd3);
                set_reg(isv_pkg::CFG_ERR_LIMIT, 32'd7);
            end
            4: begin
                lo = $urandom_range(60);
                set_reg(isv_pkg::CFG_LOW_THRESHOLD, junk7(lo));
                set_reg(isv_pkg::CFG_HIGH_THRESHOLD,
                        junk7($urandom_range(int'(isv_pkg::MOISTURE_MAX), lo + 1)));
                set_reg(isv_pkg::CFG_WARN_LIMIT, 32'($urandom_range(20)));
                set_reg(isv_pkg::CFG_ERR_LIMIT, 32'($urandom_range(20)));
            end
            default: begin
                set_reg(isv_pkg::CFG_LOW_THRESHOLD, $urandom());
                set_reg(isv_pkg::CFG_HIGH_THRESHOLD, $urandom());
                set_reg(isv_pkg::CFG_WARN_LIMIT,
                        $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(30)));
                set_reg(isv_pkg::CFG_ERR_LIMIT,
                        $urandom_range(3) == 0 ? $urandom() : 32'($urandom_range(30)));
            end
        endcase
        // A write past the register list must change nothing.
        set_reg(3'($urandom_range(7, int'(isv_pkg::CFG_ERR_LIMIT) + 1)), $urandom());
    endtask

    // Main sequence: reset, directed events, then random phases.
    initial begin
        int             sent;
        int             burst;
        isv_pkg::t_item it;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed events with the reset register values.
        send_item(mk(isv_pkg::OP_READ_HIST, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_READ_HIST, 7'd127, 1'b1, isv_pkg::ST_CRITICAL, 8'hFF,
                     8'hFF));
        send_item(mk(isv_pkg::OP_SAMPLE, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_SAMPLE, 7'd127, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_SAMPLE, 7'd25, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_SAMPLE, 7'd19, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_FORCE, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_SAMPLE, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_EXIT_FORCE, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_SET_ENABLE, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_SAMPLE, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_SET_ENABLE, 7'd0, 1'b1, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_FORCE, 7'd0, 1'b1, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_SET_STATE, 7'd0, 1'b0, isv_pkg::ST_WARNING, 8'hA5, 8'd0));
        send_item(mk(isv_pkg::OP_TICK, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_REPORT_ERR, 7'd0, 1'b0, isv_pkg::ST_ERROR, 8'hFF, 8'd0));
        send_item(mk(isv_pkg::OP_FORCE, 7'd0, 1'b1, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_SET_ENABLE, 7'd0, 1'b1, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_SET_ENABLE, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0));
        send_item(mk(isv_pkg::OP_REPORT_ERR, 7'd0, 1'b0, isv_pkg::ST_CRITICAL, 8'd0,
                     8'd0));
        send_item(mk(isv_pkg::OP_SET_STATE, 7'd0, 1'b0, isv_pkg::ST_CRITICAL, 8'h42,
                     8'd0));
        send_item(mk(isv_pkg::OP_CLEAR_ERR, 7'd0, 1'b0, isv_pkg::ST_CRITICAL, 8'h11,
                     8'd0));
        send_item(mk(isv_pkg::OP_SET_STATE, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'h7F, 8'd0));
        it = mk(isv_pkg::OP_TICK, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0, 8'd0);
        it.opcode = 4'(isv_pkg::OP_READ_HIST + 1);
        send_item(it);
        it.opcode = '1;
        send_item(it);
        for (int k = 0; k < 5; k++)
            send_item(mk(isv_pkg::OP_READ_HIST, 7'd0, 1'b0, isv_pkg::ST_NORMAL, 8'd0,
                         8'(k)));

        // Random phases, each under its own register setting.
        for (int ph = 1; ph <= 6; ph++) begin
            settle();
            apply_setting(ph);
            settings_run++;
            no_idle = (ph == 3);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(99) < 8) begin
                    // A run of ticks long enough to reach small timeouts.
                    burst = $urandom_range(25, 1);
                    repeat (burst) begin
                        it = rand_event();
                        it.opcode = isv_pkg::OP_TICK;
                        send_item(it);
                    end
                    sent += burst;
                end else begin
                    send_item(rand_event());
                    sent++;
                end
                if ($urandom_range(199) == 0)
                    settle();
            end
        end

        no_idle = 1'b0;
        settle();
        repeat (4) @(posedge i_clk);
        $display("Covered %0d items under %0d register settings; %0d results checked.",
                 shadow.noted, settings_run, shadow.checked);
        $display("Mismatches seen: %0d.", shadow.mismatches);
        if (shadow.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
